### rtl/assert_macros.svh
// Assertion helpers shared by grmce_front and grmce_queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
        else $error("assertion lbl failed");

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("assertion lbl failed");

`endif

### rtl/grmce_pkg.sv
package grmce_pkg;

    localparam int VALUE_W         = 32;
    localparam int COL_W           = 7;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [COL_W-1:0] COUNT_RESET = 7'd64;

    // s_tdata: value; m_tdata: column_index, max_value, padding to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // one finished row, column still 0-based
    typedef struct packed {
        logic [COL_W-1:0]          column;
        logic signed [VALUE_W-1:0] value;
        logic                      fallback;
    } row_result_t;

    // write side of the result queue
    typedef struct packed {
        logic        push;
        row_result_t data;
    } q_wr_t;

endpackage

### rtl/greedy_row_max_column_exclusion.sv
// Greedy row maximum with column exclusion.
// Slave stream: one matrix element per request, row by row in column order;
//   s_tdata carries the signed value, s_tuser marks the first element of a
//   new matrix, which clears the used-column mask and restarts the row.
// Master stream: one request per finished row with the 1-based column, the
//   value there and a fallback flag (set when every column was already used
//   and the overall row maximum was taken instead).
// column_count_we / column_count_wdata write the columns-per-row register
//   (0 acts as 1, values above MAX_COLUMNS act as MAX_COLUMNS); write it only
//   while the block is idle.
// Throughput: one element per cycle while the queue has room; the front unit updates
//   both running maxima and the used mask in the same cycle, so rows follow back to back.
// Result path: the edge that takes a row's last element writes the result queue;
//   the output register then loads from the queue once it is empty or being
//   drained, and m_tvalid rises with it.
// Stall: a QUEUE_DEPTH-entry result queue plus the output register absorb a
//   stalled master; s_tready drops only when the queue is full.
// Reset: used mask and row position clear, column count returns to 64, queue
//   and output register empty.
module greedy_row_max_column_exclusion
    import grmce_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 column_count_we,
    input  logic [COL_W-1:0]     column_count_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                 s_tuser,   // [0] new_matrix
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [6:0] column_index, [38:7] max_value, [39] zero
    output logic                 m_tuser    // [0] fallback
);

    q_wr_t       q_wr;
    row_result_t q_data;
    logic        q_empty;
    logic        q_full;
    logic        q_pop;
    logic        in_accept;

    // take an element whenever the result queue has room
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    grmce_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .column_count_we    (column_count_we),
        .column_count_wdata (column_count_wdata),
        .in_accept          (in_accept),
        .in_value           ($signed(s_tdata[VALUE_W-1:0])),
        .in_new_matrix      (s_tuser),
        .q_wr               (q_wr)
    );

    grmce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .pop     (q_pop),
        .rd_data (q_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    grmce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/grmce_front.sv
`include "assert_macros.svh"

module grmce_front
    import grmce_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      column_count_we,
    input  logic [COL_W-1:0]          column_count_wdata,
    input  logic                      in_accept,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic                      in_new_matrix,
    output q_wr_t                     q_wr
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_COLUMNS);

    logic [COL_W-1:0]          count_reg;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [MAX_COLUMNS-1:0]    mask_reg, mask_next;
    logic                      free_valid_reg, free_valid_next;
    logic signed [VALUE_W-1:0] free_val_reg, free_val_next;
    logic [CW-1:0]             free_idx_reg, free_idx_next;
    logic signed [VALUE_W-1:0] any_val_reg, any_val_next;
    logic [CW-1:0]             any_idx_reg, any_idx_next;

    logic [COL_W-1:0]          width_eff;
    logic [COL_W-1:0]          half_width;
    logic [CW-1:0]             col;
    logic                      first_col;
    logic                      last_col;
    logic [MAX_COLUMNS-1:0]    mask_base;
    logic                      col_used;
    logic                      valid_eff;
    logic                      take_free;
    logic                      row_valid;
    logic signed [VALUE_W-1:0] row_free_val;
    logic [CW-1:0]             row_free_idx;
    logic [COL_W-1:0]          c_ext;
    logic [COL_W:0]            c_twice;
    logic [COL_W-1:0]          partner_ext;
    logic [CW-1:0]             partner;

    // Clamp the column count into 1 .. MAX_COLUMNS
    always_comb
    begin
        if (count_reg == '0)
        begin
            width_eff = COL_W'(1);
        end
        else if (count_reg > MAX_COL)
        begin
            width_eff = MAX_COL;
        end
        else
        begin
            width_eff = count_reg;
        end
        half_width = width_eff >> 1;
    end

    always_comb
    begin
        col       = in_new_matrix ? '0 : cnt_reg;
        first_col = (col == '0);
        last_col  = ((COL_W'(col) + COL_W'(1)) >= width_eff);
        mask_base = in_new_matrix ? '0 : mask_reg;
        col_used  = mask_base[col];

        // overall maximum, ties kept at the lower column
        if (first_col || (in_value > any_val_reg))
        begin
            any_val_next = in_value;
            any_idx_next = col;
        end
        else
        begin
            any_val_next = any_val_reg;
            any_idx_next = any_idx_reg;
        end

        // maximum over free columns
        valid_eff = first_col ? 1'b0 : free_valid_reg;
        take_free = !col_used && (!valid_eff || (in_value > free_val_reg));
        if (take_free)
        begin
            row_valid    = 1'b1;
            row_free_val = in_value;
            row_free_idx = col;
        end
        else
        begin
            row_valid    = valid_eff;
            row_free_val = free_val_reg;
            row_free_idx = free_idx_reg;
        end

        // partner column sits half a row away
        c_ext       = COL_W'(row_free_idx);
        c_twice     = {c_ext, 1'b0};
        partner_ext = (c_twice < {1'b0, width_eff}) ? (c_ext + half_width)
                                                    : (c_ext - half_width);
        partner     = partner_ext[CW-1:0];

        cnt_next        = cnt_reg;
        mask_next       = mask_reg;
        free_valid_next = free_valid_reg;
        free_val_next   = free_val_reg;
        free_idx_next   = free_idx_reg;
        if (in_accept)
        begin
            free_val_next = row_free_val;
            free_idx_next = row_free_idx;
            if (last_col)
            begin
                cnt_next        = '0;
                free_valid_next = 1'b0;
                if (row_valid)
                begin
                    mask_next = mask_base
                              | (MAX_COLUMNS'(1) << row_free_idx)
                              | (MAX_COLUMNS'(1) << partner);
                end
                else
                begin
                    mask_next = mask_base;
                end
            end
            else
            begin
                cnt_next        = col + CW'(1);
                free_valid_next = row_valid;
                mask_next       = mask_base;
            end
        end

        q_wr.push          = in_accept && last_col;
        q_wr.data.fallback = !row_valid;
        if (row_valid)
        begin
            q_wr.data.column = COL_W'(row_free_idx);
            q_wr.data.value  = row_free_val;
        end
        else
        begin
            q_wr.data.column = COL_W'(any_idx_next);
            q_wr.data.value  = any_val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_RESET;
            cnt_reg        <= '0;
            mask_reg       <= '0;
            free_valid_reg <= 1'b0;
        end
        else
        begin
            if (column_count_we)
            begin
                count_reg <= column_count_wdata;
            end
            cnt_reg        <= cnt_next;
            mask_reg       <= mask_next;
            free_valid_reg <= free_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_val_reg <= free_val_next;
        free_idx_reg <= free_idx_next;
        if (in_accept)
        begin
            any_val_reg <= any_val_next;
            any_idx_reg <= any_idx_next;
        end
    end

    `ASSERT_NEXT(a_row_end_wraps, clk, rst_n, q_wr.push, cnt_reg == '0)
    `ASSERT_NEXT(a_row_end_clears_free, clk, rst_n, q_wr.push, !free_valid_reg)

endmodule

### rtl/grmce_queue.sv
`include "assert_macros.svh"

module grmce_queue
    import grmce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_wr_t       q_wr,
    input  logic        pop,
    output row_result_t rd_data,
    output logic        empty,
    output logic        full
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    row_result_t     mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   fill_reg, fill_next;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        empty   = (fill_reg == '0);
        full    = (fill_reg == NW'(DEPTH));
        do_push = q_wr.push;
        do_pop  = pop && !empty;
        rd_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end

        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + NW'(1);
            2'b01:   fill_next = fill_reg - NW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

    `ASSERT_ALWAYS(a_no_push_when_full, clk, rst_n, !(q_wr.push && full))
    `ASSERT_ALWAYS(a_fill_in_range, clk, rst_n, fill_reg <= NW'(DEPTH))

endmodule

### rtl/grmce_back.sv
module grmce_back
    import grmce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  row_result_t          q_data,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [6:0] column_index, [38:7] max_value, [39] zero
    output logic                 m_tuser   // [0] fallback
);

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_flag_reg;
    logic                 load;
    logic [COL_W-1:0]     col_one_based;

    always_comb
    begin
        // refill the output register when it is empty or being drained
        load           = !out_valid_reg || m_tready;
        q_pop          = load && !q_empty;
        out_valid_next = load ? !q_empty : out_valid_reg;
        col_one_based  = q_data.column + COL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= {{(M_TDATA_W - VALUE_W - COL_W){1'b0}},
                             q_data.value, col_one_based};
            out_flag_reg <= q_data.fallback;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

### tb/sv/greedy_row_max_column_exclusion_tb.sv
`timescale 1ns / 1ps

module greedy_row_max_column_exclusion_tb;
    import grmce_pkg::*;

    // Give up after this many cycles in which neither side takes a request.
    localparam int STALL_LIMIT = 5000;
    // Cycles to let pass after the last row result before touching the register.
    localparam int SETTLE_CYCLES = 8;

    // One finished row as the block should report it.
    typedef struct {
        logic [COL_W-1:0]          column_index;
        logic signed [VALUE_W-1:0] max_value;
        logic                      fallback;
    } row_pick_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 column_count_we = 1'b0;
    logic [COL_W-1:0]     column_count_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;      // [31:0] value
    logic                 s_tuser = 1'b0;    // [0] new_matrix
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;           // [6:0] column_index, [38:7] max_value, [39] zero
    logic                 m_tuser;           // [0] fallback

    greedy_row_max_column_exclusion uut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .column_count_we    (column_count_we),
        .column_count_wdata (column_count_wdata),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser)
    );

    // Idle rates in percent for the element sender and the result receiver.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned mismatches = 0;
    int unsigned elements_sent = 0;
    int unsigned stall_cycles = 0;

    // Rows the block has still to report, oldest first.
    row_pick_t row_picks_due[$];
    row_pick_t got_pick;
    row_pick_t want_pick;

    // Own copy of the block state: register, used columns and the running maxima.
    logic [COL_W-1:0]          cols_reg = COUNT_RESET;
    logic [63:0]               used_cols = '0;
    int                        row_pos = 0;
    logic signed [VALUE_W-1:0] free_best = '0;
    int                        free_best_col = 0;
    bit                        free_best_ok = 1'b0;
    logic signed [VALUE_W-1:0] any_best = '0;
    int                        any_best_col = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Columns per row as the block sees them: zero acts as one, large values clip.
    function automatic int active_cols();
        int w;
        w = int'(cols_reg);
        if (w == 0)
            w = 1;
        if (w > MAX_COLUMNS_DEF)
            w = MAX_COLUMNS_DEF;
        return w;
    endfunction

    // Fold one accepted element into the row state; queue a pick when the row closes.
    function automatic void fold_element(logic signed [VALUE_W-1:0] v, bit first_of_matrix);
        int        w;
        int        col;
        int        mate;
        row_pick_t pick;
        w = active_cols();
        // A new matrix clears the used columns and restarts the row, dropping any partial row.
        if (first_of_matrix)
        begin
            used_cols = '0;
            row_pos = 0;
        end
        col = row_pos;
        if (col == 0)
        begin
            free_best_ok = 1'b0;
            any_best = v;
            any_best_col = 0;
        end
        else if (v > any_best)
        begin
            any_best = v;
            any_best_col = col;
        end
        // Strictly greater only, so ties keep the lower column.
        if (!used_cols[col] && (!free_best_ok || v > free_best))
        begin
            free_best_ok = 1'b1;
            free_best = v;
            free_best_col = col;
        end
        // The row closes at the first position at or beyond count - 1.
        if (col + 1 < w)
        begin
            row_pos = col + 1;
            return;
        end
        row_pos = 0;
        if (free_best_ok)
        begin
            // Mark the pick and its partner half a row away.
            mate = (2 * free_best_col < w) ? free_best_col + w / 2 : free_best_col - w / 2;
            used_cols[free_best_col] = 1'b1;
            used_cols[mate & 63] = 1'b1;
            pick.column_index = COL_W'(free_best_col + 1);
            pick.max_value = free_best;
            pick.fallback = 1'b0;
        end
        else
        begin
            // Every column taken: fall back to the row maximum, mark nothing.
            pick.column_index = COL_W'(any_best_col + 1);
            pick.max_value = any_best;
            pick.fallback = 1'b1;
        end
        free_best_ok = 1'b0;
        row_picks_due.push_back(pick);
    endfunction

    // Send one element request; hold it until taken, then fold it into the prediction.
    task automatic send_element(logic signed [VALUE_W-1:0] v, bit first_of_matrix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= first_of_matrix;
        do
            @(posedge clk);
        while (!s_tready);
        fold_element(v, first_of_matrix);
        elements_sent++;
    endtask

    // Drop valid and wait for every outstanding row result, then let the pipeline settle.
    task automatic drain_rows();
        s_tvalid <= 1'b0;
        while (row_picks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the columns-per-row register, only with the block idle.
    task automatic set_column_count(logic [COL_W-1:0] cols);
        drain_rows();
        column_count_we    <= 1'b1;
        column_count_wdata <= cols;
        @(posedge clk);
        column_count_we <= 1'b0;
        cols_reg = cols;
    endtask

    // Mostly full-range values, with plenty of near-ties and the extremes.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0, 1: return $urandom;
            2: return $signed($urandom_range(4)) - 2;
            default:
            begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    // A register write picked mostly small, sometimes large, clipped or zero.
    function automatic logic [COL_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return COL_W'($urandom_range(8, 1));
        if (r < 85)
            return COL_W'($urandom_range(16, 9));
        if (r < 92)
            return COL_W'($urandom_range(64, 17));
        if (r < 96)
            return COL_W'($urandom_range(127, 65));
        return '0;
    endfunction

    // Receiver: stall at the current rate, fresh decision every cycle.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Check every row result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_pick.column_index = m_tdata[COL_W-1:0];
            got_pick.max_value    = m_tdata[COL_W+VALUE_W-1:COL_W];
            got_pick.fallback     = m_tuser;
            if (row_picks_due.size() == 0)
            begin
                $error("row result with nothing due: column_index %0d max_value %0d fallback %0b",
                       got_pick.column_index, got_pick.max_value, got_pick.fallback);
                mismatches++;
            end
            else
            begin
                want_pick = row_picks_due.pop_front();
                if (got_pick.column_index !== want_pick.column_index)
                begin
                    $error("column_index: expected %0d, got %0d",
                           want_pick.column_index, got_pick.column_index);
                    mismatches++;
                end
                if (got_pick.max_value !== want_pick.max_value)
                begin
                    $error("max_value: expected %0d, got %0d",
                           want_pick.max_value, got_pick.max_value);
                    mismatches++;
                end
                if (got_pick.fallback !== want_pick.fallback)
                begin
                    $error("fallback: expected %0b, got %0b",
                           want_pick.fallback, got_pick.fallback);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles without a request taken on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // One column: every column is its own partner, so the second row falls back.
    task automatic test_single_column();
        set_column_count(COL_W'(1));
        send_element(32'sh7fff_ffff, 1'b1);
        send_element(32'sh8000_0000, 1'b0);
        send_element(-32'sd1, 1'b0);
    endtask

    // Count of zero behaves as one column.
    task automatic test_zero_count();
        set_column_count('0);
        send_element(32'sd0, 1'b1);
        send_element(32'sh1234_5678, 1'b0);
    endtask

    // Two columns: a tie goes low and marks both, then the next rows fall back.
    task automatic test_tie_and_fallback();
        set_column_count(COL_W'(2));
        send_element(32'sd5, 1'b1);
        send_element(32'sd5, 1'b0);
        send_element(-32'sd3, 1'b0);
        send_element(32'sd7, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
    endtask

    // New matrix flag mid-row: drop the partial row and restart at column one.
    task automatic test_restart_mid_row();
        set_column_count(COL_W'(3));
        send_element(32'sd100, 1'b1);
        send_element(32'sd200, 1'b0);
        send_element(-32'sd9, 1'b1);
        send_element(32'sd4, 1'b0);
        send_element(32'sd4, 1'b0);
    endtask

    // Shrink the count with a row half done: the row closes on the next element.
    task automatic test_count_change_mid_row();
        set_column_count(COL_W'(3));
        send_element(32'sd1, 1'b1);
        send_element(32'sd2, 1'b0);
        set_column_count(COL_W'(2));
        send_element(32'sd3, 1'b0);
        set_column_count(COL_W'(4));
        send_element(32'sd8, 1'b1);
        set_column_count(COL_W'(1));
        send_element(-32'sd8, 1'b0);
    endtask

    // Random matrices of whole rows with some broken rows and stray restarts mixed in.
    task automatic test_random_rows(int unsigned sender_pct, int unsigned receiver_pct,
                                    logic [COL_W-1:0] first_count, int unsigned quota);
        int unsigned      stop_at;
        int               w;
        int               rows;
        int               row_len;
        logic [COL_W-1:0] cols;
        bit               first_write;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at = elements_sent + quota;
        first_write = 1'b1;
        while (elements_sent < stop_at)
        begin
            cols = first_write ? first_count : pick_count();
            first_write = 1'b0;
            set_column_count(cols);
            w = active_cols();
            repeat ($urandom_range(3, 1))
            begin
                // Small rows get enough rows to exhaust the columns; wide ones stay short.
                if (w <= 8)
                    rows = $urandom_range(w + 3, 1);
                else if (w <= 16)
                    rows = $urandom_range(4, 1);
                else
                    rows = 1;
                for (int r = 0; r < rows; r++)
                begin
                    row_len = w;
                    if (w > 1 && $urandom_range(9) == 0)
                        row_len = $urandom_range(w - 1, 1);
                    for (int c = 0; c < row_len; c++)
                    begin
                        // Open each matrix with the flag most of the time; rare stray flags.
                        if (r == 0 && c == 0)
                            send_element(pick_value(), $urandom_range(9) != 0);
                        else
                            send_element(pick_value(), $urandom_range(39) == 0);
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 34;
        recv_idle_pct = 59;
        test_single_column();
        test_zero_count();
        test_tie_and_fallback();
        test_restart_mid_row();
        test_count_change_mid_row();

        // Receiver idles most first, then the sender, then neither.
        test_random_rows(34, 59, COL_W'(127), 200);
        test_random_rows(59, 34, COL_W'(64), 200);
        test_random_rows(0, 0, COL_W'(5), 200);

        drain_rows();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/grmce_pkg.sv
rtl/grmce_front.sv
rtl/grmce_queue.sv
rtl/grmce_back.sv
rtl/greedy_row_max_column_exclusion.sv
tb/sv/greedy_row_max_column_exclusion_tb.sv
